// ----- hw/rtl/integer_expression_evaluator_top_defines.svh -----
// ----------------------------------------------------------------------------
// Expression evaluator assertion macros
// Shared concurrent check forms for the evaluator RTL.
// ----------------------------------------------------------------------------
`ifndef INTEGER_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH
`define INTEGER_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted
`define IEVAL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ieval same-cycle check failed");

// Next-cycle implication, masked while reset is asserted
`define IEVAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ieval next-cycle check failed");

`endif

// ----- hw/rtl/ieval_pkg.sv -----
// ----------------------------------------------------------------------------
// ieval_pkg
// Character codes and the control bundle for the serial multiply/divide unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ieval_pkg;

    // Character codes with meaning in an expression
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_MUL   = 8'h2A;
    localparam logic [7:0] CHAR_DIV   = 8'h2F;
    localparam logic [7:0] CHAR_ADD   = 8'h2B;
    localparam logic [7:0] CHAR_SUB   = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [3:0] DIGIT_BASE = 4'd10;

    // Start request to the serial multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } t_md_ctrl;

endpackage

`default_nettype wire

// ----- hw/rtl/integer_expression_evaluator_top.sv -----
// ----------------------------------------------------------------------------
// integer_expression_evaluator_top
// Character-stream integer expression evaluator with * / over + - precedence.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                     | tuser
//  ---------+-----------+---------------------------+------------------
//  s        | in        | [7:0] char_code           | -
//  m        | out       | [31:0] value (signed)     | [0] div_error
//
//  A digit, space or ignored character is taken without leaving ST_IDLE.
//  An operator passes through ST_CLOSE and ST_POST, and through ST_WAIT
//  while the bit-serial multiply/divide unit (one bit a cycle) closes a
//  pending '*' or '/'. '=' then goes to ST_EMIT to load the output
//  register, and waits there while an earlier result is still held by a
//  stalled output. Synchronous active-low reset clears all expression
//  state; no input item is taken while an item is being worked on.
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_expression_evaluator_top_defines.svh"

module integer_expression_evaluator_top #(
    parameter int WORD_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input characters
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [7:0]         i_s_tdata,   // [7:0] char_code
    // results
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic signed [31:0]      o_m_tdata,   // [31:0] value
    output logic [0:0]              o_m_tuser    // [0] div_error
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CLOSE = 5'b00010,
        ST_WAIT  = 5'b00100,
        ST_POST  = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

    typedef enum logic [2:0] {
        KIND_MUL = 3'd0,
        KIND_DIV = 3'd1,
        KIND_ADD = 3'd2,
        KIND_SUB = 3'd3,
        KIND_EQ  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_MUL  = 2'd1,
        PEND_DIV  = 2'd2
    } t_pend;

    t_state                r_state, n_state;
    t_kind                 r_kind, n_kind;
    t_pend                 r_pend, n_pend;
    logic                  r_sign, n_sign;
    logic                  r_err, n_err;
    logic [WORD_WIDTH-1:0] r_sum, n_sum;
    logic [WORD_WIDTH-1:0] r_term, n_term;
    logic [WORD_WIDTH-1:0] r_number, n_number;
    logic                  r_out_valid, n_out_valid;
    logic [31:0]           r_out_value, n_out_value;
    logic                  r_out_err, n_out_err;

    ieval_pkg::t_md_ctrl   md_ctrl;
    logic                  md_done;
    logic [WORD_WIDTH-1:0] md_result;

    logic                  s_accept;
    logic                  out_free;
    logic [3:0]            digit;

    assign s_accept = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;
    assign digit    = i_s_tdata[3:0];

    // Serial multiply/divide for closing a number into the open term
    ieval_serial_md #(
        .WORD_WIDTH(WORD_WIDTH)
    ) u_md (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (md_ctrl),
        .i_a      (r_term),
        .i_b      (r_number),
        .o_done   (md_done),
        .o_result (md_result)
    );

    // Next-state and datapath
    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_pend      = r_pend;
        n_sign      = r_sign;
        n_err       = r_err;
        n_sum       = r_sum;
        n_term      = r_term;
        n_number    = r_number;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_err   = r_out_err;
        md_ctrl     = '0;

        // Drop the held result once taken
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    if (i_s_tdata inside {[ieval_pkg::CHAR_ZERO:ieval_pkg::CHAR_NINE]}) begin
                        // number = number * 10 + digit, as two shifts and adds
                        n_number = (r_number << 3) + (r_number << 1)
                                 + {{(WORD_WIDTH-4){1'b0}}, digit};
                    end else if (i_s_tdata == ieval_pkg::CHAR_MUL) begin
                        n_kind  = KIND_MUL;
                        n_state = ST_CLOSE;
                    end else if (i_s_tdata == ieval_pkg::CHAR_DIV) begin
                        n_kind  = KIND_DIV;
                        n_state = ST_CLOSE;
                    end else if (i_s_tdata == ieval_pkg::CHAR_ADD) begin
                        n_kind  = KIND_ADD;
                        n_state = ST_CLOSE;
                    end else if (i_s_tdata == ieval_pkg::CHAR_SUB) begin
                        n_kind  = KIND_SUB;
                        n_state = ST_CLOSE;
                    end else if (i_s_tdata == ieval_pkg::CHAR_EQ) begin
                        n_kind  = KIND_EQ;
                        n_state = ST_CLOSE;
                    end
                end
            end

            ST_CLOSE: begin
                // Fold the typed number into the open term
                case (r_pend)
                    PEND_MUL: begin
                        md_ctrl.start  = 1'b1;
                        md_ctrl.is_div = 1'b0;
                        n_state        = ST_WAIT;
                    end
                    PEND_DIV: begin
                        if (r_number == '0) begin
                            n_err    = 1'b1;
                            n_term   = '0;
                            n_number = '0;
                            n_state  = ST_POST;
                        end else begin
                            md_ctrl.start  = 1'b1;
                            md_ctrl.is_div = 1'b1;
                            n_state        = ST_WAIT;
                        end
                    end
                    default: begin
                        n_term   = r_number;
                        n_number = '0;
                        n_state  = ST_POST;
                    end
                endcase
            end

            ST_WAIT: begin
                if (md_done) begin
                    n_term   = md_result;
                    n_number = '0;
                    n_state  = ST_POST;
                end
            end

            ST_POST: begin
                n_state = ST_IDLE;
                case (r_kind)
                    KIND_MUL: n_pend = PEND_MUL;
                    KIND_DIV: n_pend = PEND_DIV;
                    KIND_ADD, KIND_SUB, KIND_EQ: begin
                        // Fold the open term into the sum
                        n_sum  = r_sign ? (r_sum - r_term) : (r_sum + r_term);
                        n_term = '0;
                        n_pend = PEND_NONE;
                        n_sign = (r_kind == KIND_SUB);
                        if (r_kind == KIND_EQ) begin
                            n_state = ST_EMIT;
                        end
                    end
                    default: n_state = ST_IDLE;
                endcase
            end

            ST_EMIT: begin
                // Load the result and clear the expression
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_err ? 32'd0 : 32'(r_sum);
                    n_out_err   = r_err;
                    n_sum       = '0;
                    n_term      = '0;
                    n_number    = '0;
                    n_pend      = PEND_NONE;
                    n_sign      = 1'b0;
                    n_err       = 1'b0;
                    n_state     = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // Control and expression state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_kind      <= KIND_ADD;
            r_pend      <= PEND_NONE;
            r_sign      <= 1'b0;
            r_err       <= 1'b0;
            r_sum       <= '0;
            r_term      <= '0;
            r_number    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_pend      <= n_pend;
            r_sign      <= n_sign;
            r_err       <= n_err;
            r_sum       <= n_sum;
            r_term      <= n_term;
            r_number    <= n_number;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_out_value <= n_out_value;
        r_out_err   <= n_out_err;
    end

    assign o_s_tready   = (r_state == ST_IDLE);
    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_value;
    assign o_m_tuser[0] = r_out_err;

    // Checks
    `IEVAL_ASSERT_NOW(a_md_done_in_wait, i_clk, i_rst_n, md_done, r_state == ST_WAIT)
    `IEVAL_ASSERT_NOW(a_err_value_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0], o_m_tdata == 32'sd0)
    `IEVAL_ASSERT_NEXT(a_emit_clears, i_clk, i_rst_n, (r_state == ST_EMIT) && out_free, (r_sum == '0) && (r_number == '0) && !r_err && o_m_tvalid)
    `IEVAL_ASSERT_NEXT(a_close_leaves, i_clk, i_rst_n, r_state == ST_CLOSE, (r_state == ST_WAIT) || (r_state == ST_POST))

endmodule

`default_nettype wire

// ----- hw/rtl/ieval_serial_md.sv -----
// ----------------------------------------------------------------------------
// ieval_serial_md
// Bit-serial multiply (shift-add) and signed restoring divide, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ieval_serial_md #(
    parameter int WORD_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire ieval_pkg::t_md_ctrl    i_ctrl,
    input  wire logic [WORD_WIDTH-1:0]  i_a,
    input  wire logic [WORD_WIDTH-1:0]  i_b,
    output logic                        o_done,
    output logic [WORD_WIDTH-1:0]       o_result
);

    localparam int CW = $clog2(WORD_WIDTH + 1);
    localparam logic [CW-1:0] CNT_LOAD = CW'(WORD_WIDTH);
    localparam logic [WORD_WIDTH-1:0] ONE_W = WORD_WIDTH'(1);

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic                  r_div;
    logic                  r_neg;
    logic [WORD_WIDTH-1:0] r_acc;
    logic [WORD_WIDTH-1:0] r_shf;
    logic [WORD_WIDTH-1:0] r_opnd;
    logic [WORD_WIDTH-1:0] r_result;

    logic                  neg_a;
    logic                  neg_b;
    logic [WORD_WIDTH-1:0] mag_a;
    logic [WORD_WIDTH-1:0] mag_b;
    logic [WORD_WIDTH:0]   rem_sh;
    logic [WORD_WIDTH:0]   diff;

    // Magnitudes of the operands for the divide
    assign neg_a = i_a[WORD_WIDTH-1];
    assign neg_b = i_b[WORD_WIDTH-1];
    assign mag_a = neg_a ? ((~i_a) + ONE_W) : i_a;
    assign mag_b = neg_b ? ((~i_b) + ONE_W) : i_b;

    // Shift the next dividend bit into the partial remainder and trial-subtract
    assign rem_sh = {r_acc, r_shf[WORD_WIDTH-1]};
    assign diff   = rem_sh - {1'b0, r_opnd};

    // Sequence: load, WORD_WIDTH iterations, then the result step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_LOAD;
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - 1'b1;
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: one product or quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_div <= i_ctrl.is_div;
            r_acc <= '0;
            if (i_ctrl.is_div) begin
                r_shf  <= mag_a;
                r_opnd <= mag_b;
                r_neg  <= neg_a ^ neg_b;
            end else begin
                r_shf  <= i_b;
                r_opnd <= i_a;
                r_neg  <= 1'b0;
            end
        end else if (r_busy && (r_cnt != '0)) begin
            if (r_div) begin
                if (!diff[WORD_WIDTH]) begin
                    r_acc <= diff[WORD_WIDTH-1:0];
                    r_shf <= {r_shf[WORD_WIDTH-2:0], 1'b1};
                end else begin
                    r_acc <= rem_sh[WORD_WIDTH-1:0];
                    r_shf <= {r_shf[WORD_WIDTH-2:0], 1'b0};
                end
            end else begin
                if (r_shf[0]) begin
                    r_acc <= r_acc + r_opnd;
                end
                r_shf  <= r_shf >> 1;
                r_opnd <= r_opnd << 1;
            end
        end else if (r_busy) begin
            // Apply the quotient sign, or hand over the product
            if (r_div) begin
                r_result <= r_neg ? ((~r_shf) + ONE_W) : r_shf;
            end else begin
                r_result <= r_acc;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire
